// ----- rtl/pcsb_pkg.sv -----
// Shared constants, types and tables of the point cloud scan binning block.
package pcsb_pkg;

    localparam int NUM_BINS     = 1024;
    localparam int CORDIC_STEPS = 16;
    localparam int ISQRT_STEPS  = 16;
    localparam int DIV_STEPS    = 16;
    localparam int ATAN_ENTRIES = 24;

    localparam int IDX_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CALC_STEPS = (CORDIC_STEPS > ISQRT_STEPS) ? CORDIC_STEPS : ISQRT_STEPS;
    localparam int CNT_W      = (IDX_W > 5) ? IDX_W : 5;
    localparam int CX_W       = 20;
    localparam int Z_W        = 26;

    localparam logic signed [Z_W-1:0] HALF_TURN = Z_W'(8388608);

    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [1:0] STS_DONE    = 2'd0;
    localparam logic [1:0] STS_INVALID = 2'd1;
    localparam logic [1:0] STS_HEIGHT  = 2'd2;
    localparam logic [1:0] STS_READ    = 2'd3;

    localparam logic [1:0] REG_Z_LOW       = 2'd0;
    localparam logic [1:0] REG_Z_HIGH      = 2'd1;
    localparam logic [1:0] REG_RANGE_LIMIT = 2'd2;
    localparam logic [1:0] REG_BIN_WIDTH   = 2'd3;

    typedef struct packed {
        logic signed [15:0] z_low;
        logic signed [15:0] z_high;
        logic [15:0]        range_limit;
        logic [15:0]        bin_width;
    } t_cfg;

    typedef struct packed {
        logic             start;
        logic             calc;
        logic             div_init;
        logic             div_step;
        logic             idx_ld;
        logic             mem_rd;
        logic             upd;
        logic             rd_res;
        logic             clr_wr;
        logic             ld_out;
        logic [1:0]       status;
        logic [CNT_W-1:0] cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic invalid;
        logic out_of_band;
    } t_dp_sts;

    // atan(2^-i) in units of 2^-24 turn
    function automatic logic signed [Z_W-1:0] atan_lut(input logic [4:0] i);
        logic signed [Z_W-1:0] v;
        case (i)
            5'd0:  v = Z_W'(2097152);
            5'd1:  v = Z_W'(1238021);
            5'd2:  v = Z_W'(654136);
            5'd3:  v = Z_W'(332050);
            5'd4:  v = Z_W'(166669);
            5'd5:  v = Z_W'(83416);
            5'd6:  v = Z_W'(41718);
            5'd7:  v = Z_W'(20860);
            5'd8:  v = Z_W'(10430);
            5'd9:  v = Z_W'(5215);
            5'd10: v = Z_W'(2608);
            5'd11: v = Z_W'(1304);
            5'd12: v = Z_W'(652);
            5'd13: v = Z_W'(326);
            5'd14: v = Z_W'(163);
            5'd15: v = Z_W'(81);
            5'd16: v = Z_W'(41);
            5'd17: v = Z_W'(20);
            5'd18: v = Z_W'(10);
            5'd19: v = Z_W'(5);
            5'd20: v = Z_W'(3);
            5'd21: v = Z_W'(1);
            5'd22: v = Z_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/point_cloud_to_scan_binning.sv -----
// Angular scan binning of 3D points: nearest and farthest range per bin.
// An add item runs through 16 shared steps of the CORDIC angle unit and
// the bit-pair square root, an angle rounding step, 16 steps of the
// restoring divider by the bin width, then index clamp, memory read,
// read-modify-write of the bin and the output load. A read item runs the
// memory read and the result capture before the output load; a rejected
// point or an unused function goes straight to the output load. A clear
// item sweeps the bin memory one entry a cycle; after reset the same sweep
// runs before the first item is accepted. The input takes no new item
// until the last one is through. One result register sits at the output;
// while a result waits there, the next finished item holds the block and
// the input stays closed.
// Configuration registers sit at byte addresses 0, 4, 8 and 12.
module point_cloud_to_scan_binning (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [1:0]          i_func,
    input  logic signed [15:0]  i_point_x,
    input  logic signed [15:0]  i_point_y,
    input  logic signed [15:0]  i_point_z,
    input  logic                i_point_valid,
    input  logic [9:0]          i_read_index,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [1:0]          o_status,
    output logic [9:0]          o_bin_index,
    output logic [15:0]         o_near_range,
    output logic [15:0]         o_far_range
);
    import pcsb_pkg::*;

    t_cfg    cfg;
    t_dp_cmd cmd;
    t_dp_sts sts;

    pcsb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_func  (i_func),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pcsb_dp u_dp (
        .i_clk         (i_clk),
        .i_cfg         (cfg),
        .i_cmd         (cmd),
        .i_func        (i_func),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_point_z     (i_point_z),
        .i_point_valid (i_point_valid),
        .i_read_index  (i_read_index),
        .o_sts         (sts),
        .o_status      (o_status),
        .o_bin_index   (o_bin_index),
        .o_near_range  (o_near_range),
        .o_far_range   (o_far_range)
    );

endmodule

// ----- rtl/pcsb_regs.sv -----
// Configuration register bank with APB-style access.
module pcsb_regs (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [3:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    output pcsb_pkg::t_cfg       o_cfg
);
    import pcsb_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.z_low       <= 16'sh8000;
            r_cfg.z_high      <= 16'sh7FFF;
            r_cfg.range_limit <= 16'd65534;
            r_cfg.bin_width   <= 16'd64;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                REG_Z_LOW:       r_cfg.z_low       <= pwdata[15:0];
                REG_Z_HIGH:      r_cfg.z_high      <= pwdata[15:0];
                REG_RANGE_LIMIT: r_cfg.range_limit <= pwdata[15:0];
                default:         r_cfg.bin_width   <= pwdata[15:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_Z_LOW:       prdata = {16'd0, r_cfg.z_low};
            REG_Z_HIGH:      prdata = {16'd0, r_cfg.z_high};
            REG_RANGE_LIMIT: prdata = {16'd0, r_cfg.range_limit};
            default:         prdata = {16'd0, r_cfg.bin_width};
        endcase
    end

endmodule

// ----- rtl/pcsb_dp.sv -----
// Datapath: CORDIC angle, integer square root, bin divider and bin memory.
module pcsb_dp (
    input  logic                 i_clk,
    input  pcsb_pkg::t_cfg       i_cfg,
    input  pcsb_pkg::t_dp_cmd    i_cmd,
    input  logic [1:0]           i_func,
    input  logic signed [15:0]   i_point_x,
    input  logic signed [15:0]   i_point_y,
    input  logic signed [15:0]   i_point_z,
    input  logic                 i_point_valid,
    input  logic [9:0]           i_read_index,
    output pcsb_pkg::t_dp_sts    o_sts,
    output logic [1:0]           o_status,
    output logic [9:0]           o_bin_index,
    output logic [15:0]          o_near_range,
    output logic [15:0]          o_far_range
);
    import pcsb_pkg::*;

    logic [31:0]             r_mem [NUM_BINS];
    logic [31:0]             r_rd_data;
    logic signed [CX_W-1:0]  r_cx, r_cy;
    logic signed [Z_W-1:0]   r_z;
    logic [31:0]             r_sq_n, r_sq_r;
    logic [16:0]             r_rem;
    logic [15:0]             r_quo;
    logic [IDX_W-1:0]        r_addr;
    logic                    r_rd_ok;
    logic [9:0]              r_rb;
    logic [15:0]             r_rn, r_rf;
    logic [1:0]              r_status;
    logic [9:0]              r_ob;
    logic [15:0]             r_on, r_of;

    logic signed [CX_W-1:0]  x_ext, y_ext, sh_x, sh_y;
    logic signed [31:0]      sqx, sqy;
    logic [31:0]             sq_bit, sq_trial;
    logic signed [Z_W-1:0]   z_rnd, ang;
    logic [15:0]             u_clamp, bw_eff;
    logic [16:0]             d_trial;
    logic [15:0]             clr_val, rng, near_cur, far_cur, new_n, new_f;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic [31:0]             wr_data;

    assign o_sts.invalid     = !i_point_valid;
    assign o_sts.out_of_band = (i_point_z < i_cfg.z_low) ||
                               (i_point_z > i_cfg.z_high);

    assign x_ext  = CX_W'(i_point_x);
    assign y_ext  = CX_W'(i_point_y);
    assign sqx    = i_point_x * i_point_x;
    assign sqy    = i_point_y * i_point_y;
    assign sh_x   = r_cx >>> i_cmd.cnt[4:0];
    assign sh_y   = r_cy >>> i_cmd.cnt[4:0];
    assign sq_bit = 32'h4000_0000 >> {i_cmd.cnt[3:0], 1'b0};
    assign sq_trial = r_sq_r + sq_bit;

    // round to 2^-16 turn, offset from -pi; plus pi folds into the last bin
    assign z_rnd = r_z + Z_W'(128);
    assign ang   = (z_rnd >>> 8) + Z_W'(32768);
    always_comb begin
        if (ang < 0)
            u_clamp = 16'd0;
        else if (ang > Z_W'(65535))
            u_clamp = 16'hFFFF;
        else
            u_clamp = ang[15:0];
    end

    assign bw_eff  = (i_cfg.bin_width < 16'd64) ? 16'd64 : i_cfg.bin_width;
    assign d_trial = {r_rem[15:0], r_quo[15]};

    assign clr_val  = (i_cfg.range_limit == 16'hFFFF) ? 16'hFFFF :
                      i_cfg.range_limit + 16'd1;
    assign rng      = r_sq_r[15:0];
    assign near_cur = r_rd_data[31:16];
    assign far_cur  = r_rd_data[15:0];
    assign new_n    = (rng < near_cur) ? rng : near_cur;
    assign new_f    = (rng > far_cur) ? rng : far_cur;

    always_comb begin
        wr_en   = i_cmd.clr_wr || i_cmd.upd;
        wr_addr = i_cmd.clr_wr ? i_cmd.cnt[IDX_W-1:0] : r_addr;
        wr_data = i_cmd.clr_wr ? {clr_val, 16'd0} : {new_n, new_f};
    end

    always_ff @(posedge i_clk) begin
        if (wr_en)
            r_mem[wr_addr] <= wr_data;
        if (i_cmd.mem_rd)
            r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            if (i_point_x < 0) begin
                r_cx <= -x_ext;
                r_cy <= -y_ext;
                r_z  <= (i_point_y >= 0) ? HALF_TURN : -HALF_TURN;
            end else begin
                r_cx <= x_ext;
                r_cy <= y_ext;
                r_z  <= '0;
            end
            r_sq_n  <= $unsigned(sqx) + $unsigned(sqy);
            r_sq_r  <= '0;
            r_addr  <= IDX_W'(i_read_index);
            r_rd_ok <= ({22'd0, i_read_index} < 32'(NUM_BINS));
            r_rb    <= (i_func == FUNC_READ) ? i_read_index : 10'd0;
            r_rn    <= '0;
            r_rf    <= '0;
        end
        if (i_cmd.calc) begin
            if (i_cmd.cnt < CNT_W'(CORDIC_STEPS)) begin
                if (r_cy > 0) begin
                    r_cx <= r_cx + sh_y;
                    r_cy <= r_cy - sh_x;
                    r_z  <= r_z + atan_lut(i_cmd.cnt[4:0]);
                end else if (r_cy < 0) begin
                    r_cx <= r_cx - sh_y;
                    r_cy <= r_cy + sh_x;
                    r_z  <= r_z - atan_lut(i_cmd.cnt[4:0]);
                end
            end
            if (i_cmd.cnt < CNT_W'(ISQRT_STEPS)) begin
                if (r_sq_n >= sq_trial) begin
                    r_sq_n <= r_sq_n - sq_trial;
                    r_sq_r <= (r_sq_r >> 1) + sq_bit;
                end else begin
                    r_sq_r <= r_sq_r >> 1;
                end
            end
        end
        if (i_cmd.div_init) begin
            r_quo <= u_clamp;
            r_rem <= '0;
        end
        if (i_cmd.div_step) begin
            if (d_trial >= {1'b0, bw_eff}) begin
                r_rem <= d_trial - {1'b0, bw_eff};
                r_quo <= {r_quo[14:0], 1'b1};
            end else begin
                r_rem <= d_trial;
                r_quo <= {r_quo[14:0], 1'b0};
            end
        end
        if (i_cmd.idx_ld) begin
            if (r_quo > 16'(NUM_BINS - 1))
                r_addr <= IDX_W'(NUM_BINS - 1);
            else
                r_addr <= IDX_W'(r_quo);
        end
        if (i_cmd.upd) begin
            r_rn <= new_n;
            r_rf <= new_f;
            r_rb <= 10'(r_addr);
        end
        if (i_cmd.rd_res) begin
            r_rn <= r_rd_ok ? near_cur : 16'd0;
            r_rf <= r_rd_ok ? far_cur : 16'd0;
        end
        if (i_cmd.ld_out) begin
            r_status <= i_cmd.status;
            r_ob     <= r_rb;
            r_on     <= r_rn;
            r_of     <= r_rf;
        end
    end

    assign o_status     = r_status;
    assign o_bin_index  = r_ob;
    assign o_near_range = r_on;
    assign o_far_range  = r_of;

endmodule

// ----- rtl/pcsb_ctrl.sv -----
// Controller state machine: sequences clear sweep, point update and bin read.
module pcsb_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_func,
    output logic                 o_valid,
    input  logic                 i_ready,
    input  pcsb_pkg::t_dp_sts    i_sts,
    output pcsb_pkg::t_dp_cmd    o_cmd
);
    import pcsb_pkg::*;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CALC  = 4'd2;
    localparam logic [3:0] S_ANG   = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_IDX   = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_UPD   = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    logic [3:0]       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_is_add, n_is_add;
    logic [1:0]       r_status, n_status;
    logic             r_clr_item, n_clr_item;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign o_ready  = (r_state == S_IDLE);
    assign o_valid  = r_out_valid;
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_is_add   = r_is_add;
        n_status   = r_status;
        n_clr_item = r_clr_item;
        o_cmd        = '0;
        o_cmd.cnt    = r_cnt;
        o_cmd.status = r_status;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (r_cnt == CNT_W'(NUM_BINS - 1)) begin
                    n_cnt   = '0;
                    n_state = r_clr_item ? S_DONE : S_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_cnt       = '0;
                    n_is_add    = (i_func == FUNC_ADD);
                    unique case (i_func)
                        FUNC_CLEAR: begin
                            n_status   = STS_DONE;
                            n_clr_item = 1'b1;
                            n_state    = S_CLEAR;
                        end
                        FUNC_ADD: begin
                            if (i_sts.invalid) begin
                                n_status = STS_INVALID;
                                n_state  = S_DONE;
                            end else if (i_sts.out_of_band) begin
                                n_status = STS_HEIGHT;
                                n_state  = S_DONE;
                            end else begin
                                n_status = STS_DONE;
                                n_state  = S_CALC;
                            end
                        end
                        FUNC_READ: begin
                            n_status = STS_READ;
                            n_state  = S_RD;
                        end
                        default: begin
                            n_status = STS_DONE;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_CALC: begin
                o_cmd.calc = 1'b1;
                if (r_cnt == CNT_W'(CALC_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ANG;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ANG: begin
                o_cmd.div_init = 1'b1;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_IDX;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_IDX: begin
                o_cmd.idx_ld = 1'b1;
                n_state      = S_RD;
            end
            S_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd    = r_is_add;
                o_cmd.rd_res = !r_is_add;
                n_state      = S_DONE;
            end
            S_DONE: begin
                // hold the finished item until the output register frees up
                if (out_free) begin
                    o_cmd.ld_out = 1'b1;
                    n_clr_item   = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        if (o_cmd.ld_out)
            n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_is_add    <= 1'b0;
            r_status    <= STS_DONE;
            r_clr_item  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_is_add    <= n_is_add;
            r_status    <= n_status;
            r_clr_item  <= n_clr_item;
            r_out_valid <= n_out_valid;
        end
    end

endmodule
